FILE: hdl/four_pole_ladder_lowpass_defines.svh
// Assertion macros for the ladder filter
`ifndef FOUR_POLE_LADDER_LOWPASS_DEFINES_SVH
`define FOUR_POLE_LADDER_LOWPASS_DEFINES_SVH
`ifndef SYNTHESIS
`define FPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/fpl_pkg.sv
`timescale 1ns / 1ps
package fpl_pkg;
    localparam int CHANNELS_DEF = 32;
    localparam int CHW = 5;
    localparam int SW = 24;
    localparam int HZW = 16;
    localparam int RESW = 16;
    localparam logic [31:0] SCALE_RST = 32'd2848995;
    localparam logic signed [63:0] Q30_ONE  = 64'sd1073741824;
    localparam logic signed [63:0] K_0005   = 64'sd5368709;
    localparam logic signed [63:0] K_116    = 64'sd1245540516;
    localparam logic signed [63:0] K_015    = 64'sd161061274;
    localparam logic signed [63:0] K_035013 = 64'sd375949225;
    localparam logic signed [63:0] K_03     = 64'sd322122547;

    // Datapath operation codes
    typedef enum logic [4:0] {
        OP_NONE, OP_LIN, OP_C, OP_F, OP_F2, OP_F4, OP_G, OP_T, OP_FB,
        OP_RD, OP_X1, OP_X2, OP_PA, OP_PB, OP_PW, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] pole;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic in_range;
    } stat_t;

    // Round-to-nearest (ties up) shift by 30 of a product
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] q;
        begin
            q = p + 64'sd536870912;
            return q >>> 30;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction
endpackage

FILE: hdl/fpl_if.sv
`timescale 1ns / 1ps
interface fpl_in_if import fpl_pkg::*;;
    logic valid;
    logic ready;
    logic [CHW-1:0] channel;
    logic signed [SW-1:0] sample_in;
    logic [HZW-1:0] cutoff_hz;
    logic [RESW-1:0] resonance;
    modport source (output valid, channel, sample_in, cutoff_hz, resonance, input ready);
    modport sink (input valid, channel, sample_in, cutoff_hz, resonance, output ready);
endinterface

interface fpl_out_if import fpl_pkg::*;;
    logic valid;
    logic ready;
    logic [CHW-1:0] out_channel;
    logic signed [SW-1:0] sample_out;
    modport source (output valid, out_channel, sample_out, input ready);
    modport sink (input valid, out_channel, sample_out, output ready);
endinterface

FILE: hdl/fpl_datapath.sv
`timescale 1ns / 1ps
module fpl_datapath import fpl_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [31:0]           scale,
    input  logic [CHW-1:0]        channel,
    input  logic signed [SW-1:0]  sample_in,
    input  logic [HZW-1:0]        cutoff_hz,
    input  logic [RESW-1:0]       resonance,
    output stat_t                 stat,
    output logic [CHW-1:0]        out_channel,
    output logic signed [SW-1:0]  sample_out
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * 8;
    localparam int MAW = AW + 3;

    // State memory: entry = {channel, pole, kind}; kind 0 output, 1 previous input.
    // A per-channel flag marks channels that have completed a sample since reset; others read as zero.
    logic signed [31:0] mem [DEPTH];
    logic [CHANNELS-1:0] vld_reg;
    logic signed [31:0] rd_reg;

    logic [CHW-1:0] ch_reg;
    logic signed [SW-1:0] smp_reg;
    logic [HZW-1:0] hz_reg;
    logic [RESW-1:0] res_reg;
    logic signed [63:0] c_reg, f_reg, f2_reg, g_reg, fb_reg, t_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [63:0] acc64_reg;
    logic signed [SW-1:0] out_reg;
    logic [CHW-1:0] out_ch_reg;
    logic [MAW-1:0] raddr, waddr;
    logic signed [31:0] wdata;
    logic we;
    logic signed [63:0] ma, mb, prod;
    logic signed [69:0] prod_full;
    logic signed [63:0] lin;
    logic [AW-1:0] chi;
    logic signed [63:0] o;

    assign chi = ch_reg[AW-1:0];
    assign stat.in_range = ({27'd0, ch_reg} < 32'(CHANNELS));
    assign out_channel = out_ch_reg;
    assign sample_out = out_reg;

    // Shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_LIN: begin ma = {48'd0, hz_reg}; mb = {32'd0, scale}; end
            OP_F:   begin ma = c_reg; mb = K_116; end
            OP_F2:  begin ma = f_reg; mb = f_reg; end
            OP_F4:  begin ma = f2_reg; mb = f2_reg; end
            OP_G:   begin ma = K_035013; mb = t_reg; end
            OP_T:   begin ma = K_015; mb = f2_reg; end
            OP_FB:  begin ma = {48'd0, res_reg}; mb = t_reg; end
            OP_X1:  begin ma = 64'(rd_reg); mb = fb_reg; end
            OP_X2:  begin ma = 64'(x_reg); mb = g_reg; end
            OP_PA:  begin ma = K_03; mb = 64'(rd_reg); end
            OP_PB:  begin ma = Q30_ONE - f_reg; mb = 64'(rd_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    // Signed 35 x 35 product; every operand fits in 35 signed bits
    assign prod_full = $signed(ma[34:0]) * $signed(mb[34:0]);
    assign prod = prod_full[63:0];

    // Memory read address follows the op being set up
    always_comb
    begin
        raddr = {chi, cmd.pole, 1'b0};
        if (cmd.op == OP_RD)
            raddr = {chi, 2'd3, 1'b0};
        else if (cmd.op == OP_X2)
            raddr = {chi, cmd.pole, 1'b1};
        else if (cmd.op == OP_PA)
            raddr = {chi, cmd.pole, 1'b0};
    end

    // Store previous input during OP_PB, pole output during OP_PW
    always_comb
    begin
        o = (64'(y_reg) + 64'sd16) >>> 5;
        we = 1'b0;
        waddr = {chi, cmd.pole, 1'b0};
        wdata = y_reg;
        if (stat.in_range)
        begin
            if (cmd.op == OP_PB)
            begin
                we = 1'b1;
                waddr = {chi, cmd.pole, 1'b1};
                wdata = x_reg;
            end
            else if (cmd.op == OP_PW)
                we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= vld_reg[chi] ? mem[raddr] : 32'sd0;
        if (we)
            mem[waddr] <= wdata;
    end

    // Mark a channel once its sample has completed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.op == OP_OUT && stat.in_range)
            vld_reg[chi] <= 1'b1;
    end

    assign lin = 64'(prod[63:6]);

    // Sequenced arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg <= channel;
            smp_reg <= sample_in;
            hz_reg <= cutoff_hz;
            res_reg <= resonance;
        end
        case (cmd.op)
            OP_LIN: c_reg <= (lin >= Q30_ONE) ? Q30_ONE : lin + K_0005;
            OP_C:   if (c_reg > Q30_ONE) c_reg <= Q30_ONE;
            OP_F:   f_reg <= rnd30(prod);
            OP_F2:  f2_reg <= rnd30(prod);
            OP_F4:  t_reg <= rnd30(prod);
            OP_G:   g_reg <= rnd30(prod);
            OP_T:   t_reg <= Q30_ONE - rnd30(prod);
            OP_FB:  fb_reg <= (prod + 64'sd8192) >>> 14;
            OP_RD:  ;
            OP_X1:  x_reg <= sat32(64'(smp_reg) * 64'sd32 - rnd30(prod));
            // apply the input gain ahead of the first pole only
            OP_X2:  if (cmd.pole == 2'd0) x_reg <= sat32(rnd30(prod));
            OP_PA:  begin acc64_reg <= 64'(x_reg) + rnd30(prod); end
            OP_PB:  y_reg <= sat32(acc64_reg + rnd30(prod));
            OP_PW:  x_reg <= y_reg;
            OP_OUT:
            begin
                out_ch_reg <= ch_reg;
                if (!stat.in_range)
                    out_reg <= '0;
                else if (o > 64'sd8388607)
                    out_reg <= 24'sh7fffff;
                else if (o < -64'sd8388608)
                    out_reg <= 24'sh800000;
                else
                    out_reg <= o[SW-1:0];
            end
            default: ;
        endcase
    end
endmodule

FILE: hdl/fpl_ctrl.sv
`timescale 1ns / 1ps
module fpl_ctrl import fpl_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_LIN, S_C, S_F, S_F2, S_F4, S_G, S_T, S_FB, S_RD, S_X1, S_X2,
        S_PA, S_PB, S_PW, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] pole_reg, pole_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    // Output register can take a new result this cycle
    assign out_free = !out_valid_reg || out_ready;

    // Issue commands per state
    always_comb
    begin
        cmd.pole = pole_reg;
        cmd.load = in_valid && in_ready;
        case (state_reg)
            S_LIN: cmd.op = OP_LIN;
            S_C:   cmd.op = OP_C;
            S_F:   cmd.op = OP_F;
            S_F2:  cmd.op = OP_F2;
            S_F4:  cmd.op = OP_F4;
            S_G:   cmd.op = OP_G;
            S_T:   cmd.op = OP_T;
            S_FB:  cmd.op = OP_FB;
            S_RD:  cmd.op = OP_RD;
            S_X1:  cmd.op = OP_X1;
            S_X2:  cmd.op = OP_X2;
            S_PA:  cmd.op = OP_PA;
            S_PB:  cmd.op = OP_PB;
            S_PW:  cmd.op = OP_PW;
            S_OUT: cmd.op = out_free ? OP_OUT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pole_next = pole_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE: if (in_valid && in_ready) state_next = S_LIN;
            S_LIN:  state_next = S_C;
            S_C:    state_next = S_F;
            S_F:    state_next = S_F2;
            S_F2:   state_next = S_F4;
            S_F4:   state_next = S_G;
            S_G:    state_next = S_T;
            S_T:    state_next = S_FB;
            S_FB:   state_next = S_RD;
            S_RD:   state_next = S_X1;
            S_X1:   begin state_next = S_X2; pole_next = 2'd0; end
            S_X2:   state_next = S_PA;
            S_PA:   state_next = S_PB;
            S_PB:   state_next = S_PW;
            S_PW:
                if (pole_reg == 2'd3)
                    state_next = S_OUT;
                else
                begin
                    pole_next = pole_reg + 2'd1;
                    state_next = S_X2;
                end
            // Hold here while the previous result is still unclaimed
            S_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pole_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pole_reg <= pole_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

FILE: hdl/four_pole_ladder_lowpass.sv
`timescale 1ns / 1ps
// Four-pole resonant ladder low-pass, one sample per transaction with per-channel
// state. One shared multiplier is stepped by a controller: each sample runs from
// acceptance through the cutoff terms and the feedback-corrected input, then the
// four poles in turn through one state memory, then a step that registers the
// result, before the next sample can be accepted. The result is held in an
// output register until taken; the next sample may enter meanwhile but waits
// in its last step while the earlier result is unclaimed. Filter state reads
// as zero for a channel until its first sample completes. The cutoff scale
// register sits at address 0.
`include "four_pole_ladder_lowpass_defines.svh"
module four_pole_ladder_lowpass import fpl_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fpl_in_if.sink      in_ch,
    fpl_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] scale_reg;
    cmd_t cmd;
    stat_t stat;
    logic in_take;
    logic out_wait;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? scale_reg : 32'd0;
    assign in_take = in_ch.valid && in_ch.ready;
    assign out_wait = out_ch.valid && !out_ch.ready;

    // Hold the cutoff scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RST;
        else if (psel && penable && pwrite && paddr == 2'd0)
            scale_reg <= pwdata;
    end

    fpl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat(stat), .cmd(cmd)
    );

    fpl_datapath #(.CHANNELS(CHANNELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .scale(scale_reg),
        .channel(in_ch.channel), .sample_in(in_ch.sample_in),
        .cutoff_hz(in_ch.cutoff_hz), .resonance(in_ch.resonance), .stat(stat),
        .out_channel(out_ch.out_channel), .sample_out(out_ch.sample_out)
    );

    `FPL_ASSERT_NEXT(a_accept_clears, clk, rst_n, in_take, !in_ch.ready, "ready after accept")
    `FPL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_ch.valid, "result dropped")
    `FPL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_wait, $stable(out_ch.sample_out), "result moved")
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import fpl_pkg::*;

    localparam int NCH = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    fpl_in_if in_ch ();
    fpl_out_if out_ch ();

    int mismatches = 0;
    bit quiet = 0;
    bit hold_req = 0;
    int idle_cycles = 0;

    four_pole_ladder_lowpass uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    typedef struct {
        logic [CHW-1:0] ch;
        logic signed [SW-1:0] smp;
    } filt_result_t;

    // Filter predictor: per-channel ladder state plus queue of pending samples
    class ladder_scoreboard;
        logic [31:0] scale;
        int pole_y[4][NCH];
        int pole_x[4][NCH];
        filt_result_t pending[$];

        function new();
            scale = SCALE_RST;
            foreach (pole_y[i, j])
            begin
                pole_y[i][j] = 0;
                pole_x[i][j] = 0;
            end
        endfunction

        function longint round_shift(input longint p, input int s);
            return (p + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint q30_product(input longint a, input longint b);
            return round_shift(a * b, 30);
        endfunction

        function int clip32(input longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return int'(v);
        endfunction

        function void note_input(input logic [CHW-1:0] ch, input logic signed [SW-1:0] smp,
                                 input logic [HZW-1:0] hz, input logic [RESW-1:0] res);
            longint lin, c, f, f2, f4, g, fb, decay, o;
            int x, y, k;
            filt_result_t r;
            r.ch = ch;
            r.smp = '0;
            if (ch < NCH)
            begin
                k = int'(ch);
                lin = (longint'(hz) * longint'({32'd0, scale})) >>> 6;
                if (lin >= Q30_ONE)
                    c = Q30_ONE;
                else
                begin
                    c = K_0005 + lin;
                    if (c > Q30_ONE)
                        c = Q30_ONE;
                end
                f = q30_product(c, K_116);
                f2 = q30_product(f, f);
                f4 = q30_product(f2, f2);
                g = q30_product(K_035013, f4);
                fb = round_shift(longint'(res) * (Q30_ONE - q30_product(K_015, f2)), 14);
                decay = Q30_ONE - f;
                x = clip32(longint'(smp) * 32 - q30_product(pole_y[3][k], fb));
                x = clip32(q30_product(x, g));
                // advance the four poles in turn
                y = x;
                for (int p = 0; p < 4; p++)
                begin
                    x = y;
                    y = clip32(longint'(x) + q30_product(K_03, pole_x[p][k])
                               + q30_product(decay, pole_y[p][k]));
                    pole_y[p][k] = y;
                    pole_x[p][k] = x;
                end
                o = round_shift(y, 5);
                if (o > 8388607)
                    o = 8388607;
                if (o < -8388608)
                    o = -8388608;
                r.smp = o[SW-1:0];
            end
            pending.push_back(r);
        endfunction

        task check_result(input logic [CHW-1:0] ch, input logic signed [SW-1:0] smp);
            filt_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result ch=%0d sample=%0d", ch, smp));
                return;
            end
            e = pending.pop_front();
            if (ch !== e.ch)
                report($sformatf("out_channel %0d, expected %0d", ch, e.ch));
            if (smp !== e.smp)
                report($sformatf("ch %0d sample_out %0d, expected %0d", e.ch, smp, e.smp));
        endtask
    endclass

    ladder_scoreboard sb = new();

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Check each result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.out_channel, out_ch.sample_out);
    end

    // Drive result ready with random stalls and requested hold-offs
    initial
    begin
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_scale(input logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= '0;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.scale = value;
    endtask

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(input logic [CHW-1:0] ch, input logic signed [SW-1:0] smp,
                               input logic [HZW-1:0] hz, input logic [RESW-1:0] res);
        in_ch.valid <= 1;
        in_ch.channel <= ch;
        in_ch.sample_in <= smp;
        in_ch.cutoff_hz <= hz;
        in_ch.resonance <= res;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        sb.note_input(ch, smp, hz, res);
        if (!quiet && $urandom_range(0, 99) < 6)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic signed [SW-1:0] smp;
        logic [HZW-1:0] hz;
        case ($urandom_range(0, 3))
            0: smp = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: smp = SW'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: hz = HZW'($urandom_range(0, 2000));
            1: hz = HZW'($urandom_range(0, 20000));
            default: hz = HZW'($urandom);
        endcase
        send_sample(CHW'($urandom_range(0, NCH - 1)), smp, hz, RESW'($urandom));
    endtask

    task automatic settle();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] scales[5];
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 0;
        in_ch.channel = '0;
        in_ch.sample_in = '0;
        in_ch.cutoff_hz = '0;
        in_ch.resonance = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes of samples, cutoffs and resonance
        send_sample(5'd0, 24'sh7fffff, 16'd0, 16'd0);
        send_sample(5'd0, 24'sh7fffff, 16'd65535, 16'd65535);
        send_sample(5'd0, 24'sh800000, 16'd65535, 16'd65535);
        send_sample(5'd31, 24'sh800000, 16'd0, 16'd65535);
        send_sample(5'd31, 24'sh7fffff, 16'd20000, 16'd16384);
        send_sample(5'd31, 24'sh000000, 16'd1000, 16'd0);
        send_sample(5'd5, 24'sh000001, 16'd65535, 16'd0);
        send_sample(5'd5, 24'shffffff, 16'd44100, 16'd65535);
        for (int i = 0; i < 6; i++)
            send_sample(5'd7, i[0] ? 24'sh7fffff : 24'sh800000, 16'd65535, 16'd65535);
        settle();

        // Clamped cutoff with maximum scale: decay goes negative
        write_scale(32'hffffffff);
        send_sample(5'd9, 24'sh7fffff, 16'd1, 16'd65535);
        send_sample(5'd9, 24'sh800000, 16'd65535, 16'd65535);
        send_sample(5'd9, 24'sh400000, 16'd300, 16'd8000);
        for (int i = 0; i < 6; i++)
            send_sample(5'd10, i[0] ? 24'sh7fffff : 24'sh800000, 16'd65535, 16'd65535);
        settle();

        scales[0] = SCALE_RST;
        scales[1] = 32'd0;
        scales[2] = 32'hffffffff;
        scales[3] = $urandom;
        scales[4] = SCALE_RST * 4;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_scale(scales[ph]);
            for (int n = 0; n < 300; n++)
            begin
                quiet = (ph == 1 && n < 200);
                if (ph == 2 && n == 50)
                    hold_req = 1;
                send_random();
            end
            quiet = 0;
            settle();
        end
        write_scale(SCALE_RST);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/fpl_pkg.sv
hdl/fpl_if.sv
hdl/fpl_datapath.sv
hdl/fpl_ctrl.sv
hdl/four_pole_ladder_lowpass.sv
tb/testbench.sv
